FILE: rtl/core/fmrt_pkg.sv
`default_nettype none

package fmrt_pkg;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_ADD    = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADIDX = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] src_base;
		logic [31:0] src_care;
		logic [31:0] dst_base;
		logic [31:0] dst_care;
	} rule_t;

	// search key travelling down the row together with the first-hit flag
	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic        hit;
	} wave_t;

	typedef struct packed {
		logic  add_en;
		logic  del_en;
		rule_t new_rule;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/fmrt_cell.sv
`default_nettype none

module fmrt_cell #(
	parameter int IDX  = 0,
	parameter int CW   = 5,
	parameter int IW   = 4,
	parameter int CMPW = 5
) (
	input  wire logic               clk,
	input  wire fmrt_pkg::cell_ctrl_t ctrl,
	input  wire logic [CW-1:0]      count,
	input  wire logic [CMPW-1:0]    del_idx,
	input  wire fmrt_pkg::rule_t    next_rule,
	output fmrt_pkg::rule_t         rule,
	input  wire fmrt_pkg::wave_t    wave_in,
	input  wire logic [IW-1:0]      idx_in,
	output fmrt_pkg::wave_t         wave_out,
	output logic [IW-1:0]           idx_out
);

	fmrt_pkg::rule_t rule_q;
	fmrt_pkg::wave_t wave_q;
	logic [IW-1:0]   idx_q;
	logic            active;
	logic            match;
	logic            ld_add;
	logic            ld_shift;

	assign active = CW'(IDX) < count;
	assign match  = active
		&& (((wave_in.src_ip ^ rule_q.src_base) & rule_q.src_care) == 32'd0)
		&& (((wave_in.dst_ip ^ rule_q.dst_base) & rule_q.dst_care) == 32'd0);

	assign ld_add   = ctrl.add_en && (count == CW'(IDX));
	assign ld_shift = ctrl.del_en && (CMPW'(IDX) >= del_idx) && (CW'(IDX + 1) < count);

	always_ff @(posedge clk) begin
		if (ld_add) begin
			rule_q <= ctrl.new_rule;
		end else if (ld_shift) begin
			rule_q <= next_rule;
		end
	end

	always_ff @(posedge clk) begin
		wave_q.src_ip <= wave_in.src_ip;
		wave_q.dst_ip <= wave_in.dst_ip;
		wave_q.hit    <= wave_in.hit | match;
		idx_q         <= wave_in.hit ? idx_in : IW'(IDX);
	end

	assign rule     = rule_q;
	assign wave_out = wave_q;
	assign idx_out  = idx_q;

endmodule

`default_nettype wire

FILE: rtl/core/first_match_route_table.sv
// channel  dir  tdata (low bit up)                                   tuser
// s_axis   in   src_ip 32, src_care 32, dst_ip 32, dst_care 32,      op 2
//               entry_index 4, 4 zero bits
// m_axis   out  hit 1, route_index 4, status 2, entry_count 5,
//               4 zero bits
//
// add, delete and the unused op go from the input registers to the output register
// a lookup finishes once the key has walked the row of rule cells one cell per
// cycle, and the first hit rides along with it
// one item at a time; the next beat is taken while a result still waits in the
// output register
// reset clears the rule count and the control state; the rule cells are not cleared
`default_nettype none

module first_match_route_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [135:0] s_axis_tdata,   // src_ip, src_care, dst_ip, dst_care, entry_index
	input  wire logic [1:0]   s_axis_tuser,   // op
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [15:0]       m_axis_tdata    // hit, route_index, status, entry_count
);

	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CMPW = (CW > 4) ? CW : 4;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t              state_q;
	fmrt_pkg::op_t       op_q;
	logic [31:0]         src_q;
	logic [31:0]         smask_q;
	logic [31:0]         dst_q;
	logic [31:0]         dmask_q;
	logic [3:0]          idx_q;
	logic [CW-1:0]       walk_q;
	logic [CW-1:0]       count_q;

	logic                out_valid_q;
	logic                out_hit_q;
	logic [3:0]          out_route_q;
	fmrt_pkg::status_t   out_status_q;
	logic [4:0]          out_count_q;

	fmrt_pkg::cell_ctrl_t ctrl;
	fmrt_pkg::rule_t     rule_c [TABLE_DEPTH];
	fmrt_pkg::wave_t     wave_c [TABLE_DEPTH + 1];
	logic [IW-1:0]       idx_c  [TABLE_DEPTH + 1];

	logic                accept;
	logic                out_free;
	logic                finish;
	logic                full;
	logic                bad_idx;
	logic                lk_hit;
	logic [3:0]          lk_route;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign full    = (count_q == CW'(TABLE_DEPTH));
	assign bad_idx = CMPW'(idx_q) >= CMPW'(count_q);

	assign finish = (state_q == S_EXEC) && out_free
		&& ((op_q != fmrt_pkg::OP_LOOKUP) || (walk_q == CW'(TABLE_DEPTH)));

	assign ctrl.add_en   = finish && (op_q == fmrt_pkg::OP_ADD) && !full;
	assign ctrl.del_en   = finish && (op_q == fmrt_pkg::OP_DELETE) && !bad_idx;
	assign ctrl.new_rule = '{src_base: src_q, src_care: smask_q,
		dst_base: dst_q, dst_care: dmask_q};

	assign wave_c[0] = '{src_ip: src_q, dst_ip: dst_q, hit: 1'b0};
	assign idx_c[0]  = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		fmrt_pkg::rule_t nb_rule;
		if (i < TABLE_DEPTH - 1) begin : g_mid
			assign nb_rule = rule_c[i + 1];
		end else begin : g_end
			assign nb_rule = rule_c[i];
		end
		fmrt_cell #(
			.IDX  (i),
			.CW   (CW),
			.IW   (IW),
			.CMPW (CMPW)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.del_idx   (CMPW'(idx_q)),
			.next_rule (nb_rule),
			.rule      (rule_c[i]),
			.wave_in   (wave_c[i]),
			.idx_in    (idx_c[i]),
			.wave_out  (wave_c[i + 1]),
			.idx_out   (idx_c[i + 1])
		);
	end

	assign lk_hit   = wave_c[TABLE_DEPTH].hit;
	assign lk_route = lk_hit ? 4'(idx_c[TABLE_DEPTH]) : 4'd0;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= fmrt_pkg::op_t'(s_axis_tuser);
			src_q   <= s_axis_tdata[31:0];
			smask_q <= s_axis_tdata[63:32];
			dst_q   <= s_axis_tdata[95:64];
			dmask_q <= s_axis_tdata[127:96];
			idx_q   <= s_axis_tdata[131:128];
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_hit_q    <= 1'b0;
			out_route_q  <= 4'd0;
			out_status_q <= fmrt_pkg::ST_OK;
			out_count_q  <= 5'(count_q);
			unique case (op_q)
				fmrt_pkg::OP_LOOKUP: begin
					out_hit_q   <= lk_hit;
					out_route_q <= lk_route;
				end
				fmrt_pkg::OP_ADD: begin
					if (full) begin
						out_status_q <= fmrt_pkg::ST_FULL;
					end else begin
						out_count_q <= 5'(count_q + CW'(1));
					end
				end
				fmrt_pkg::OP_DELETE: begin
					if (bad_idx) begin
						out_status_q <= fmrt_pkg::ST_BADIDX;
					end else begin
						out_count_q <= 5'(count_q - CW'(1));
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			walk_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.add_en) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.del_en) begin
				count_q <= count_q - CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					walk_q <= '0;
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (finish) begin
						state_q <= S_IDLE;
					end else if (walk_q != CW'(TABLE_DEPTH)) begin
						walk_q <= walk_q + CW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_count_q, out_status_q, out_route_q, out_hit_q};

endmodule

`default_nettype wire

FILE: tb/first_match_route_table_test.sv
`default_nettype none

module first_match_route_table_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] src_ip;
		logic [31:0] src_care;
		logic [31:0] dst_ip;
		logic [31:0] dst_care;
		logic [3:0]  entry_index;
		int          gap;
		bit          drain_first;
	} route_beat_t;

	typedef struct {
		logic              hit;
		logic [3:0]        route_index;
		fmrt_pkg::status_t status;
		logic [4:0]        entry_count;
	} route_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [15:0]  m_axis_tdata;

	first_match_route_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	route_beat_t     pending_beats[$];
	route_result_t   awaited_routes[$];
	fmrt_pkg::rule_t known_rules[$];
	fmrt_pkg::rule_t route_rules[TABLE_DEPTH];
	logic [4:0]      rule_total = '0;
	int              mismatches = 0;
	int              results_seen = 0;
	logic            in_taken = 1'b0;
	int              gap_left = 0;
	int              stall_left = 0;
	int              calm_left = 0;
	bit              calm = 1'b0;

	task automatic report_mismatch(string field, int want, int got);
		$display("mismatch on result %0d, %s: expected %0d got %0d",
			results_seen, field, want, got);
		mismatches++;
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_mask();
		int r;
		int len;
		r = $urandom_range(0, 99);
		len = $urandom_range(0, 32);
		if (r < 60) return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
		if (r < 75) return 32'hFFFF_FFFF;
		if (r < 85) return 32'h0;
		return $urandom;
	endfunction

	function automatic route_result_t apply_route_op(logic [1:0] op, logic [135:0] data);
		route_result_t res;
		logic [31:0]   sa;
		logic [31:0]   sm;
		logic [31:0]   da;
		logic [31:0]   dm;
		logic [3:0]    idx;
		sa = data[31:0];
		sm = data[63:32];
		da = data[95:64];
		dm = data[127:96];
		idx = data[131:128];
		res.hit = 1'b0;
		res.route_index = '0;
		res.status = fmrt_pkg::ST_OK;
		unique case (op)
			fmrt_pkg::OP_LOOKUP: begin
				for (int i = 0; i < rule_total; i++) begin
					if (!res.hit
						&& ((sa ^ route_rules[i].src_base) & route_rules[i].src_care) == 0
						&& ((da ^ route_rules[i].dst_base) & route_rules[i].dst_care) == 0)
					begin
						res.hit = 1'b1;
						res.route_index = 4'(i);
					end
				end
			end
			fmrt_pkg::OP_ADD: begin
				if (rule_total >= TABLE_DEPTH) begin
					res.status = fmrt_pkg::ST_FULL;
				end else begin
					route_rules[4'(rule_total)] = '{src_base: sa, src_care: sm,
						dst_base: da, dst_care: dm};
					rule_total++;
				end
			end
			fmrt_pkg::OP_DELETE: begin
				if (idx >= rule_total) begin
					res.status = fmrt_pkg::ST_BADIDX;
				end else begin
					for (int i = int'(idx); i + 1 < rule_total; i++)
						route_rules[i] = route_rules[i + 1];
					rule_total--;
				end
			end
			default: ;
		endcase
		res.entry_count = rule_total;
		return res;
	endfunction

	function automatic route_beat_t make_beat(logic [1:0] op, logic [31:0] sa, logic [31:0] sm,
		logic [31:0] da, logic [31:0] dm, logic [3:0] idx);
		route_beat_t b;
		b.op = op;
		b.src_ip = sa;
		b.src_care = sm;
		b.dst_ip = da;
		b.dst_care = dm;
		b.entry_index = idx;
		b.gap = 0;
		b.drain_first = 1'b0;
		return b;
	endfunction

	task automatic queue_rule(logic [31:0] sa, logic [31:0] sm, logic [31:0] da,
		logic [31:0] dm);
		pending_beats.push_back(make_beat(fmrt_pkg::OP_ADD, sa, sm, da, dm, 4'($urandom)));
		known_rules.push_back('{src_base: sa, src_care: sm, dst_base: da, dst_care: dm});
		if (known_rules.size() > 24)
			void'(known_rules.pop_front());
	endtask

	// lookup key that falls inside a rule added earlier, free bits random
	task automatic queue_lookup_near(int k);
		fmrt_pkg::rule_t r;
		r = known_rules[k];
		pending_beats.push_back(make_beat(fmrt_pkg::OP_LOOKUP,
			(r.src_base & r.src_care) | ($urandom & ~r.src_care), $urandom,
			(r.dst_base & r.dst_care) | ($urandom & ~r.dst_care), $urandom,
			4'($urandom)));
	endtask

	always @(negedge clk) begin
		bit          drive;
		route_beat_t b;
		drive = s_axis_tvalid && !in_taken;
		if (!drive && arst_n && pending_beats.size() > 0) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (!(pending_beats[0].drain_first && awaited_routes.size() > 0)) begin
				b = pending_beats.pop_front();
				drive = 1'b1;
				s_axis_tdata <= {4'b0, b.entry_index, b.dst_care, b.dst_ip, b.src_care,
					b.src_ip};
				s_axis_tuser <= b.op;
				gap_left = (pending_beats.size() > 0) ? pending_beats[0].gap : 0;
			end
		end
		s_axis_tvalid <= drive;
	end

	always @(negedge clk) begin
		if (calm_left == 0) begin
			calm = ($urandom_range(0, 99) < 30);
			calm_left = $urandom_range(50, 400);
		end else begin
			calm_left--;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n;
			if (!calm && $urandom_range(0, 99) < 25)
				stall_left = idle_len();
		end
	end

	always @(posedge clk) begin
		route_result_t want;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_routes.size() == 0) begin
					report_mismatch("unexpected result, tdata", 0, int'(m_axis_tdata));
				end else begin
					want = awaited_routes.pop_front();
					if (m_axis_tdata[0] !== want.hit)
						report_mismatch("hit", int'(want.hit), int'(m_axis_tdata[0]));
					if (m_axis_tdata[4:1] !== want.route_index)
						report_mismatch("route_index", int'(want.route_index),
							int'(m_axis_tdata[4:1]));
					if (m_axis_tdata[6:5] !== want.status)
						report_mismatch("status", int'(want.status), int'(m_axis_tdata[6:5]));
					if (m_axis_tdata[11:7] !== want.entry_count)
						report_mismatch("entry_count", int'(want.entry_count),
							int'(m_axis_tdata[11:7]));
				end
				results_seen++;
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_routes.push_back(apply_route_op(s_axis_tuser, s_axis_tdata));
		end
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int mode;
		int r;
		bit quiet;
		int first;

		// directed part
		pending_beats.push_back(make_beat(fmrt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h0, 32'h0, 4'hF));
		pending_beats.push_back(make_beat(fmrt_pkg::OP_DELETE, 32'h0, 32'h0, 32'h0, 32'h0,
			4'h0));
		queue_rule(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
		for (int i = 1; i < TABLE_DEPTH - 1; i++)
			queue_rule({4'(i), 28'($urandom)}, pick_mask(), $urandom, pick_mask());
		queue_rule(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
		pending_beats.push_back(make_beat(fmrt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
		pending_beats.push_back(make_beat(fmrt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0,
			32'hFFFF_FFFF, 4'h0));
		queue_lookup_near(7);
		pending_beats.push_back(make_beat(fmrt_pkg::OP_LOOKUP, $urandom, $urandom, $urandom,
			$urandom, 4'($urandom)));
		pending_beats.push_back(make_beat(fmrt_pkg::OP_DELETE, 32'h0, 32'h0, 32'h0, 32'h0,
			4'hF));
		pending_beats.push_back(make_beat(fmrt_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
		pending_beats.push_back(make_beat(fmrt_pkg::OP_LOOKUP, 32'h1234_5678, 32'h0,
			32'h9ABC_DEF0, 32'h0, 4'h0));
		pending_beats.push_back(make_beat(fmrt_pkg::OP_DELETE, 32'h0, 32'h0, 32'h0, 32'h0,
			4'h0));
		pending_beats.push_back(make_beat(OP_UNUSED, $urandom, $urandom, $urandom,
			$urandom, 4'($urandom)));

		// random part in blocks, each block waits for the table to drain first
		for (int blk = 0; blk < 7; blk++) begin
			mode = $urandom_range(0, 2);
			quiet = ($urandom_range(0, 99) < 25);
			first = pending_beats.size();
			for (int n = 0; n < 150; n++) begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					pending_beats.push_back(make_beat(OP_UNUSED, $urandom, $urandom,
						$urandom, $urandom, 4'($urandom)));
				end else if ((mode == 0 && r < 28) || (mode == 1 && r < 55)
					|| (mode == 2 && r < 10)) begin
					queue_rule($urandom, pick_mask(), $urandom, pick_mask());
				end else if ((mode == 0 && r < 48) || (mode == 1 && r < 60)
					|| (mode == 2 && r < 65)) begin
					pending_beats.push_back(make_beat(fmrt_pkg::OP_DELETE, $urandom, $urandom,
						$urandom, $urandom, ($urandom_range(0, 1) || mode == 2)
						? 4'($urandom_range(0, 3)) : 4'($urandom)));
				end else begin
					r = $urandom_range(0, 99);
					if (r < 65 && known_rules.size() > 0)
						queue_lookup_near($urandom_range(0, known_rules.size() - 1));
					else if (r < 75)
						pending_beats.push_back(make_beat(fmrt_pkg::OP_LOOKUP,
							{32{r[0]}}, $urandom, {32{r[1]}}, $urandom, 4'($urandom)));
					else
						pending_beats.push_back(make_beat(fmrt_pkg::OP_LOOKUP, $urandom,
							$urandom, $urandom, $urandom, 4'($urandom)));
				end
				pending_beats[pending_beats.size() - 1].gap = quiet ? 0 : idle_len();
			end
			pending_beats[first].drain_first = 1'b1;
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_beats.size() > 0 || s_axis_tvalid || awaited_routes.size() > 0)
			@(negedge clk);
		repeat (TABLE_DEPTH + 10) @(posedge clk);
		if (mismatches == 0 && awaited_routes.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/fmrt_pkg.sv
rtl/core/fmrt_cell.sv
rtl/core/first_match_route_table.sv
tb/first_match_route_table_test.sv
